>>> hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int MAX_DEPTH  = 16;
    localparam int COORD_W    = 24;
    localparam int OFF_W      = COORD_W + 1;
    localparam int EXT_W      = 5;
    localparam int PAD_W      = 2 ** EXT_W;
    localparam int DEPTH_W    = 5;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = $clog2(MASK_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_LOG2 = 2'd3;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [EXT_W-1:0] EXTENT_RESET = 5'd16;

    typedef logic [ADDR_W-1:0] node_idx_t;

    typedef struct packed {
        node_idx_t         pointer;
        logic [MASK_W-1:0] leaf;
        logic [MASK_W-1:0] valid;
    } desc_t;

    typedef struct packed {
        logic      absent;
        logic      leaf_hit;
        logic      fault;
        node_idx_t next_node;
    } step_res_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_BOUND_X = 6'b000010,
        ST_BOUND_Y = 6'b000100,
        ST_BOUND_Z = 6'b001000,
        ST_WALK    = 6'b010000,
        ST_RESULT  = 6'b100000
    } state_t;

endpackage

>>> hw/rtl/spq_desc_store.sv
module spq_desc_store
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      wr_en,
    input  node_idx_t wr_addr,
    input  desc_t     wr_data,
    input  node_idx_t rd_addr,
    output desc_t     rd_data
);

    desc_t mem [NODE_COUNT];
    desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/spq_bound_unit.sv
module spq_bound_unit
    import spq_pkg::*;
(
    input  logic [COORD_W-1:0] pos,
    input  logic [COORD_W-1:0] lo,
    input  logic [EXT_W-1:0]   extent,
    output logic [OFF_W-1:0]   offset,
    output logic               in_cube
);

    logic [OFF_W:0] diff;

    // Both operands are sign-extended by two bits, so the difference never wraps.
    assign diff    = {{2{pos[COORD_W-1]}}, pos} - {{2{lo[COORD_W-1]}}, lo};
    assign offset  = diff[OFF_W-1:0];
    assign in_cube = !diff[OFF_W] && ((offset >> extent) == '0);

endmodule

>>> hw/rtl/spq_level_unit.sv
module spq_level_unit
    import spq_pkg::*;
(
    input  desc_t               desc,
    input  logic [OFF_W-1:0]    off_x,
    input  logic [OFF_W-1:0]    off_y,
    input  logic [OFF_W-1:0]    off_z,
    input  logic [EXT_W-1:0]    extent,
    input  logic [DEPTH_W-1:0]  level,
    output step_res_t           res
);

    logic [PAD_W-1:0]  pad_x;
    logic [PAD_W-1:0]  pad_y;
    logic [PAD_W-1:0]  pad_z;
    logic [EXT_W-1:0]  bit_pos;
    logic              in_range;
    logic [2:0]        child;
    logic [MASK_W-1:0] lower_mask;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W:0]   sum;

    assign pad_x    = PAD_W'(off_x);
    assign pad_y    = PAD_W'(off_y);
    assign pad_z    = PAD_W'(off_z);
    assign in_range = EXT_W'(level) < extent;
    assign bit_pos  = extent - EXT_W'(level) - EXT_W'(1);

    // Levels below the finest lattice bit always take child bit zero.
    assign child[0] = in_range & pad_x[bit_pos];
    assign child[1] = in_range & pad_y[bit_pos];
    assign child[2] = in_range & pad_z[bit_pos];

    assign lower_mask = desc.valid & ~desc.leaf & ((MASK_W'(1) << child) - MASK_W'(1));

    always_comb
    begin
        count = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            count = count + CNT_W'(lower_mask[i]);
        end
    end

    assign sum = {1'b0, desc.pointer} + (ADDR_W + 1)'(count);

    assign res.absent    = !desc.valid[child];
    assign res.leaf_hit  = desc.leaf[child];
    assign res.fault     = sum >= (ADDR_W + 1)'(NODE_COUNT);
    assign res.next_node = sum[ADDR_W-1:0];

endmodule

>>> hw/rtl/sparse_octree_point_query_top.sv
// Point query over a sparse octree held as 4096 child descriptors in a memory with
// one write port and one registered read port. A write item stores one descriptor
// and returns an all-zero result through the result state. A query item checks
// the x, y and z bounds in turn through one shared subtractor, then reads one
// descriptor per level down to the requested depth, capped at the deepest level
// of 16, and stops early on a missing child, a leaf or a bad pointer. The input is
// not ready while an item is in progress; a finished result sits in the output
// register until taken while the next item is accepted.
// Configuration writes take effect at once and are meant only while the block is idle.
module sparse_octree_point_query_top
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [COORD_W-1:0]   pos_x,
    input  logic [COORD_W-1:0]   pos_y,
    input  logic [COORD_W-1:0]   pos_z,
    input  logic [DEPTH_W-1:0]   depth,
    input  node_idx_t            desc_index,
    input  logic [MASK_W-1:0]    desc_valid,
    input  logic [MASK_W-1:0]    desc_leaf,
    input  node_idx_t            desc_pointer,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 present,
    output logic [MASK_W-1:0]    child_mask,
    output logic                 index_fault
);

    state_t              state_reg, state_next;
    logic                tree_loaded_reg, tree_loaded_next;
    logic [COORD_W-1:0]  min_x_reg, min_x_next;
    logic [COORD_W-1:0]  min_y_reg, min_y_next;
    logic [COORD_W-1:0]  min_z_reg, min_z_next;
    logic [EXT_W-1:0]    extent_reg, extent_next;
    logic                out_valid_reg, out_valid_next;

    logic [COORD_W-1:0]  pos_x_reg, pos_x_next;
    logic [COORD_W-1:0]  pos_y_reg, pos_y_next;
    logic [COORD_W-1:0]  pos_z_reg, pos_z_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]  level_reg, level_next;
    logic [OFF_W-1:0]    off_x_reg, off_x_next;
    logic [OFF_W-1:0]    off_y_reg, off_y_next;
    logic [OFF_W-1:0]    off_z_reg, off_z_next;
    logic                res_present_reg, res_present_next;
    logic [MASK_W-1:0]   res_mask_reg, res_mask_next;
    logic                res_fault_reg, res_fault_next;
    logic                present_reg, present_next;
    logic [MASK_W-1:0]   child_mask_reg, child_mask_next;
    logic                index_fault_reg, index_fault_next;

    logic                accept;
    logic                wr_en;
    desc_t               wr_data;
    node_idx_t           rd_addr;
    desc_t               rd_data;
    logic [COORD_W-1:0]  bound_pos;
    logic [COORD_W-1:0]  bound_lo;
    logic [OFF_W-1:0]    bound_off;
    logic                bound_inside;
    step_res_t           step;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Descriptor indices are as wide as the store, so every write lands.
    assign wr_en   = accept && (opcode == OP_WRITE);
    assign wr_data = '{pointer: desc_pointer, leaf: desc_leaf, valid: desc_valid};

    // Outside the walk the store keeps reading the root, so it is ready on entry.
    assign rd_addr = (state_reg == ST_WALK) ? step.next_node : '0;

    spq_desc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (desc_index),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (state_reg)
            ST_BOUND_Y:
            begin
                bound_pos = pos_y_reg;
                bound_lo  = min_y_reg;
            end
            ST_BOUND_Z:
            begin
                bound_pos = pos_z_reg;
                bound_lo  = min_z_reg;
            end
            default:
            begin
                bound_pos = pos_x_reg;
                bound_lo  = min_x_reg;
            end
        endcase
    end

    spq_bound_unit u_bound (
        .pos     (bound_pos),
        .lo      (bound_lo),
        .extent  (extent_reg),
        .offset  (bound_off),
        .in_cube (bound_inside)
    );

    spq_level_unit u_level (
        .desc   (rd_data),
        .off_x  (off_x_reg),
        .off_y  (off_y_reg),
        .off_z  (off_z_reg),
        .extent (extent_reg),
        .level  (level_reg),
        .res    (step)
    );

    always_comb
    begin
        state_next       = state_reg;
        tree_loaded_next = tree_loaded_reg;
        min_x_next       = min_x_reg;
        min_y_next       = min_y_reg;
        min_z_next       = min_z_reg;
        extent_next      = extent_reg;
        out_valid_next   = out_valid_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        pos_z_next       = pos_z_reg;
        depth_next       = depth_reg;
        level_next       = level_reg;
        off_x_next       = off_x_reg;
        off_y_next       = off_y_reg;
        off_z_next       = off_z_reg;
        res_present_next = res_present_reg;
        res_mask_next    = res_mask_reg;
        res_fault_next   = res_fault_reg;
        present_next     = present_reg;
        child_mask_next  = child_mask_reg;
        index_fault_next = index_fault_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WORLD_MIN_X: min_x_next  = cfg_data;
                REG_WORLD_MIN_Y: min_y_next  = cfg_data;
                REG_WORLD_MIN_Z: min_z_next  = cfg_data;
                REG_EXTENT_LOG2: extent_next = cfg_data[EXT_W-1:0];
                default:         extent_next = extent_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_present_next = 1'b0;
                    res_mask_next    = '0;
                    res_fault_next   = 1'b0;
                    pos_x_next       = pos_x;
                    pos_y_next       = pos_y;
                    pos_z_next       = pos_z;
                    depth_next       = (depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                                     : depth;
                    level_next       = '0;
                    if (opcode == OP_WRITE)
                    begin
                        tree_loaded_next = 1'b1;
                        state_next       = ST_RESULT;
                    end
                    else if (!tree_loaded_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_BOUND_X;
                    end
                end
            end
            ST_BOUND_X:
            begin
                off_x_next = bound_off;
                state_next = bound_inside ? ST_BOUND_Y : ST_RESULT;
            end
            ST_BOUND_Y:
            begin
                off_y_next = bound_off;
                state_next = bound_inside ? ST_BOUND_Z : ST_RESULT;
            end
            ST_BOUND_Z:
            begin
                off_z_next = bound_off;
                state_next = bound_inside ? ST_WALK : ST_RESULT;
            end
            ST_WALK:
            begin
                if (level_reg == depth_reg)
                begin
                    res_present_next = 1'b1;
                    res_mask_next    = rd_data.valid;
                    state_next       = ST_RESULT;
                end
                else if (step.absent)
                begin
                    state_next = ST_RESULT;
                end
                else if (step.leaf_hit)
                begin
                    res_present_next = 1'b1;
                    state_next       = ST_RESULT;
                end
                else if (step.fault)
                begin
                    res_fault_next = 1'b1;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    level_next = level_reg + DEPTH_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    present_next     = res_present_reg;
                    child_mask_next  = res_mask_reg;
                    index_fault_next = res_fault_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tree_loaded_reg <= 1'b0;
            min_x_reg       <= '0;
            min_y_reg       <= '0;
            min_z_reg       <= '0;
            extent_reg      <= EXTENT_RESET;
            out_valid_reg   <= 1'b0;
            level_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            tree_loaded_reg <= tree_loaded_next;
            min_x_reg       <= min_x_next;
            min_y_reg       <= min_y_next;
            min_z_reg       <= min_z_next;
            extent_reg      <= extent_next;
            out_valid_reg   <= out_valid_next;
            level_reg       <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg       <= pos_x_next;
        pos_y_reg       <= pos_y_next;
        pos_z_reg       <= pos_z_next;
        depth_reg       <= depth_next;
        off_x_reg       <= off_x_next;
        off_y_reg       <= off_y_next;
        off_z_reg       <= off_z_next;
        res_present_reg <= res_present_next;
        res_mask_reg    <= res_mask_next;
        res_fault_reg   <= res_fault_next;
        present_reg     <= present_next;
        child_mask_reg  <= child_mask_next;
        index_fault_reg <= index_fault_next;
    end

    assign out_valid   = out_valid_reg;
    assign present     = present_reg;
    assign child_mask  = child_mask_reg;
    assign index_fault = index_fault_reg;

    // A new result beat only ever follows the result state.
    a_beat_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result beat raised outside the result state");

    // The walk never runs past the requested depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (level_reg <= depth_reg))
        else $error("walk level beyond requested depth");

    // A fault beat never claims a voxel.
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && index_fault_reg) |-> (!present_reg && child_mask_reg == '0))
        else $error("fault beat with present or mask set");

    // An accepted write marks the tree loaded.
    a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_WRITE) |=> tree_loaded_reg)
        else $error("descriptor write did not mark the tree loaded");

endmodule

>>> verif/tb_sparse_octree_point_query_top.sv
`timescale 1ns / 100ps

module tb_sparse_octree_point_query_top;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 8;

    typedef struct {
        logic              op;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        logic [DEPTH_W-1:0] dep;
        node_idx_t         di;
        logic [MASK_W-1:0] dv;
        logic [MASK_W-1:0] dl;
        node_idx_t         dp;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [MASK_W-1:0] mask;
        logic              fault;
    } lookup_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [COORD_W-1:0]   pos_z;
    logic [DEPTH_W-1:0]   depth;
    node_idx_t            desc_index;
    logic [MASK_W-1:0]    desc_valid;
    logic [MASK_W-1:0]    desc_leaf;
    node_idx_t            desc_pointer;
    logic                 out_valid;
    logic                 out_ready;
    logic                 present;
    logic [MASK_W-1:0]    child_mask;
    logic                 index_fault;

    // Shadow copy of the block's state and settings.
    desc_t                node_table [NODE_COUNT];
    bit                   node_written [NODE_COUNT];
    bit                   tree_ready;
    logic signed [COORD_W-1:0] bound_x;
    logic signed [COORD_W-1:0] bound_y;
    logic signed [COORD_W-1:0] bound_z;
    logic [EXT_W-1:0]     ext_log2;

    lookup_t              pending_results [$];
    int                   idle_pct;
    int                   stall_pct;
    int                   errors;
    int                   cycles;
    int                   n_queries;
    int                   n_writes;
    int                   n_hits;
    int                   n_absent;
    int                   n_faults;
    int                   deepest;

    sparse_octree_point_query_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .depth        (depth),
        .desc_index   (desc_index),
        .desc_valid   (desc_valid),
        .desc_leaf    (desc_leaf),
        .desc_pointer (desc_pointer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .present      (present),
        .child_mask   (child_mask),
        .index_fault  (index_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure and a field-by-field compare of every beat.
    always @(posedge clk)
    begin : result_monitor
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending: present %0b mask %02h fault %0b",
                         $time, present, child_mask, index_fault);
            end
            else
            begin
                want = pending_results.pop_front();
                if (present !== want.hit)
                begin
                    errors++;
                    $display("%0t: present expected %0b actual %0b", $time, want.hit, present);
                end
                if (child_mask !== want.mask)
                begin
                    errors++;
                    $display("%0t: child_mask expected %02h actual %02h", $time, want.mask,
                             child_mask);
                end
                if (index_fault !== want.fault)
                begin
                    errors++;
                    $display("%0t: index_fault expected %0b actual %0b", $time, want.fault,
                             index_fault);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic axis_bit(input longint off, input int lvl);
        if (lvl >= int'(ext_log2))
            return 1'b0;
        return logic'((off >> (int'(ext_log2) - 1 - lvl)) & 1);
    endfunction

    // Walks the shadow tree. gap_node reports the first entry the walk would read
    // that has never been written, so the caller can load it beforehand.
    function automatic lookup_t octree_lookup(input item_t it, output int gap_node,
                                              output int levels);
        lookup_t           r;
        longint            edge_len;
        longint            ox;
        longint            oy;
        longint            oz;
        int                lim;
        int                node;
        int                idx;
        desc_t             d;
        logic [MASK_W-1:0] below;
        r        = '0;
        gap_node = -1;
        levels   = 0;
        if (!tree_ready)
            return r;
        edge_len = longint'(1) << ext_log2;
        ox = longint'($signed(it.px)) - longint'(bound_x);
        oy = longint'($signed(it.py)) - longint'(bound_y);
        oz = longint'($signed(it.pz)) - longint'(bound_z);
        if (ox < 0 || ox >= edge_len || oy < 0 || oy >= edge_len || oz < 0 || oz >= edge_len)
            return r;
        lim  = (int'(it.dep) > MAX_DEPTH) ? MAX_DEPTH : int'(it.dep);
        node = 0;
        for (int lvl = 0; lvl < lim; lvl++)
        begin
            if (!node_written[node])
            begin
                gap_node = node;
                return r;
            end
            d      = node_table[node];
            idx    = {axis_bit(oz, lvl), axis_bit(oy, lvl), axis_bit(ox, lvl)};
            levels = lvl + 1;
            if (!d.valid[idx])
                return r;
            if (d.leaf[idx])
            begin
                r.hit = 1'b1;
                return r;
            end
            below = d.valid & ~d.leaf & ((8'd1 << idx) - 8'd1);
            node  = int'(d.pointer) + $countones(below);
            if (node >= NODE_COUNT)
            begin
                r.fault = 1'b1;
                return r;
            end
        end
        if (!node_written[node])
        begin
            gap_node = node;
            return r;
        end
        r.hit  = 1'b1;
        r.mask = node_table[node].valid;
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.op  = logic'($urandom_range(1));
        it.px  = COORD_W'($urandom);
        it.py  = COORD_W'($urandom);
        it.pz  = COORD_W'($urandom);
        it.dep = DEPTH_W'($urandom);
        it.di  = node_idx_t'($urandom);
        it.dv  = MASK_W'($urandom);
        it.dl  = MASK_W'($urandom);
        it.dp  = node_idx_t'($urandom);
        return it;
    endfunction

    function automatic item_t mk_write(input int index, input logic [MASK_W-1:0] v,
                                       input logic [MASK_W-1:0] l, input int p);
        item_t it;
        it    = rand_item();
        it.op = OP_WRITE;
        it.di = node_idx_t'(index);
        it.dv = v;
        it.dl = l;
        it.dp = node_idx_t'(p);
        return it;
    endfunction

    function automatic item_t mk_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z, input logic [DEPTH_W-1:0] d);
        item_t it;
        it     = rand_item();
        it.op  = OP_QUERY;
        it.px  = x;
        it.py  = y;
        it.pz  = z;
        it.dep = d;
        return it;
    endfunction

    // Descriptors lean towards dense interior nodes with low pointers, so that walks
    // revisit loaded entries and often run deep; a few point near the top of the store.
    function automatic item_t rand_desc(input int index);
        logic [MASK_W-1:0] v;
        logic [MASK_W-1:0] l;
        int                p;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                v = 8'hFF;
                l = 8'h00;
            end
            3:
            begin
                v = MASK_W'($urandom);
                l = MASK_W'($urandom);
            end
            4:
            begin
                v = 8'h00;
                l = MASK_W'($urandom);
            end
            default:
            begin
                v = MASK_W'($urandom | $urandom);
                l = MASK_W'($urandom & $urandom & $urandom);
            end
        endcase
        case ($urandom_range(19))
            16, 17:  p = $urandom_range(NODE_COUNT - 1, NODE_COUNT - 9);
            18, 19:  p = $urandom_range(NODE_COUNT - 1);
            default: p = $urandom_range(300);
        endcase
        return mk_write(index, v, l, p);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] lo);
        longint edge_len;
        longint v;
        edge_len = longint'(1) << ext_log2;
        case ($urandom_range(39))
            0:       v = longint'(lo) - 1;
            1:       v = longint'(lo) + edge_len;
            2:       v = longint'(lo) + edge_len - 1;
            3:       v = longint'($urandom);
            default: v = longint'(lo) + (longint'($urandom) & (edge_len - 1));
        endcase
        return v[COORD_W-1:0];
    endfunction

    task automatic send_item(input item_t it);
        lookup_t want;
        int      gap_node;
        int      lv;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= it.op;
        pos_x        <= it.px;
        pos_y        <= it.py;
        pos_z        <= it.pz;
        depth        <= it.dep;
        desc_index   <= it.di;
        desc_valid   <= it.dv;
        desc_leaf    <= it.dl;
        desc_pointer <= it.dp;
        do
            @(posedge clk);
        while (!in_ready);
        if (it.op == OP_WRITE)
        begin
            node_table[it.di]   = '{pointer: it.dp, leaf: it.dl, valid: it.dv};
            node_written[it.di] = 1'b1;
            tree_ready          = 1'b1;
            want                = '0;
            n_writes++;
        end
        else
        begin
            want = octree_lookup(it, gap_node, lv);
            n_queries++;
            if (want.hit)
                n_hits++;
            else if (want.fault)
                n_faults++;
            else
                n_absent++;
            if (lv > deepest)
                deepest = lv;
        end
        pending_results.push_back(want);
    endtask

    // Loads every unwritten entry the walk would touch before the query itself goes out.
    task automatic issue_query(input item_t it);
        lookup_t r;
        int      gap_node;
        int      lv;
        r = octree_lookup(it, gap_node, lv);
        while (gap_node >= 0)
        begin
            send_item(rand_desc(gap_node));
            r = octree_lookup(it, gap_node, lv);
        end
        send_item(it);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_WORLD_MIN_X: bound_x = data;
            REG_WORLD_MIN_Y: bound_y = data;
            REG_WORLD_MIN_Z: bound_z = data;
            REG_EXTENT_LOG2: ext_log2 = data[EXT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_world(input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my,
                             input logic [COORD_W-1:0] mz, input int ext);
        quiesce();
        cfg_write(REG_WORLD_MIN_X, mx);
        cfg_write(REG_WORLD_MIN_Y, my);
        cfg_write(REG_WORLD_MIN_Z, mz);
        cfg_write(REG_EXTENT_LOG2, COORD_W'(ext));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_before_load();
        issue_query(mk_query(24'h000000, 24'h000000, 24'h000000, 5'd5));
        issue_query(mk_query(24'h7FFFFF, 24'h800000, 24'h000000, 5'd0));
    endtask

    // A small hand-built tree under the reset world: root with two leaf children and
    // one missing child, a node whose pointer runs off the store, an all-leaf node,
    // an empty node and a self-referencing entry at the top of the store.
    task automatic test_walk_cases();
        send_item(mk_write(0, 8'h7F, 8'h03, 1));
        send_item(mk_write(1, 8'hA5, 8'h00, NODE_COUNT - 1));
        send_item(mk_write(2, 8'hFF, 8'hFF, 0));
        send_item(mk_write(3, 8'h00, 8'h00, 0));
        send_item(mk_write(NODE_COUNT - 1, 8'h01, 8'h00, NODE_COUNT - 1));
        issue_query(mk_query(24'h000000, 24'h000000, 24'h000000, 5'd0));
        issue_query(mk_query(24'h008000, 24'h008000, 24'h008000, 5'd1));
        issue_query(mk_query(24'h000000, 24'h000000, 24'h000000, 5'd1));
        issue_query(mk_query(24'h00C000, 24'h00C000, 24'h000000, 5'd2));
        issue_query(mk_query(24'h000000, 24'h000000, 24'h008000, 5'd2));
        issue_query(mk_query(24'h000000, 24'h008000, 24'h000000, 5'd1));
        issue_query(mk_query(24'h004000, 24'h00C000, 24'h004000, 5'd2));
        issue_query(mk_query(24'h000000, 24'h008000, 24'h000000, 5'd16));
        issue_query(mk_query(24'h000000, 24'h008000, 24'h000000, 5'd17));
        issue_query(mk_query(24'h000000, 24'h008000, 24'h000000, 5'd31));
    endtask

    task automatic test_bounds();
        issue_query(mk_query(24'hFFFFFF, 24'h000000, 24'h000000, 5'd0));
        issue_query(mk_query(24'h010000, 24'h000000, 24'h000000, 5'd0));
        issue_query(mk_query(24'h000000, 24'h000000, 24'h010000, 5'd0));
        issue_query(mk_query(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 5'd0));
        issue_query(mk_query(24'h800000, 24'h7FFFFF, 24'h000000, 5'd3));
    endtask

    task automatic random_item();
        item_t it;
        int    index;
        if ($urandom_range(99) < 15)
        begin
            index = ($urandom_range(1) != 0) ? $urandom_range(310) : $urandom_range(NODE_COUNT - 1);
            send_item(rand_desc(index));
        end
        else
        begin
            it    = rand_item();
            it.op = OP_QUERY;
            it.px = pick_coord(bound_x);
            it.py = pick_coord(bound_y);
            it.pz = pick_coord(bound_z);
            case ($urandom_range(9))
                0:          it.dep = DEPTH_W'($urandom_range(31, MAX_DEPTH + 1));
                1, 2, 3, 4: it.dep = DEPTH_W'($urandom_range(MAX_DEPTH, 10));
                default:    it.dep = DEPTH_W'($urandom_range(MAX_DEPTH));
            endcase
            issue_query(it);
        end
    endtask

    task automatic test_random_phases();
        int start;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: set_world(24'h000000, 24'h000000, 24'h000000, 3);
                1: set_world(24'h800000, 24'h800000, 24'h800000, 23);
                2: set_world(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
                3: set_world(24'h800000, 24'h800000, 24'h800000, 31);
                4: set_world(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 24);
                default:
                    set_world(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                              $urandom_range(23, 1));
            endcase
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            start = n_queries + n_writes;
            while (n_queries + n_writes - start < PHASE_ITEMS)
                random_item();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_WORLD_MIN_X;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_QUERY;
        pos_x        <= '0;
        pos_y        <= '0;
        pos_z        <= '0;
        depth        <= '0;
        desc_index   <= '0;
        desc_valid   <= '0;
        desc_leaf    <= '0;
        desc_pointer <= '0;
        out_ready    <= 1'b0;
        cycles       = 0;
        errors       = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        tree_ready   = 1'b0;
        bound_x      = '0;
        bound_y      = '0;
        bound_z      = '0;
        ext_log2     = EXTENT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_load();
        test_walk_cases();
        test_bounds();
        test_random_phases();

        quiesce();
        repeat (30) @(posedge clk);
        $display("Covered %0d queries and %0d descriptor writes over %0d world settings.",
                 n_queries, n_writes, PHASE_COUNT);
        $display("Outcomes: %0d present, %0d absent, %0d index faults; deepest walk %0d levels.",
                 n_hits, n_absent, n_faults, deepest);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
